// ===== rtl/urx_pkg.sv =====
// Package for the UART register bank with receive FIFO.
// Holds FIFO sizing, register and function codes, and controller types.
// No dependencies.
package urx_pkg;

  localparam int RX_DEPTH = 16;
  localparam int PTR_W    = $clog2(RX_DEPTH);
  localparam int CNT_W    = $clog2(RX_DEPTH + 1);
  localparam int WM_W     = 5;
  localparam int CMP_W    = (CNT_W > WM_W) ? CNT_W : WM_W;
  localparam int DATA_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int REG_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] RD_EMPTY = 32'h8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LINE  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_e;

  localparam logic [REG_W-1:0] REG_TXDATA = 3'd0;
  localparam logic [REG_W-1:0] REG_RXDATA = 3'd1;
  localparam logic [REG_W-1:0] REG_IP     = 3'd5;
  localparam logic [REG_W-1:0] REG_SCALER = 3'd6;
  localparam logic [REG_W-1:0] REG_CPUID  = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_RX_IRQ_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_IRQ_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_WM     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_WM     = 2'd3;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic commit;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// ===== rtl/urx_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on urx_pkg for field widths.
interface urx_req_if;
  logic                        valid;
  logic                        ready;
  logic [urx_pkg::FUNC_W-1:0]  func;
  logic [urx_pkg::REG_W-1:0]   reg_index;
  logic [urx_pkg::DATA_W-1:0]  data;

  modport source (output valid, func, reg_index, data, input ready);
  modport sink   (input valid, func, reg_index, data, output ready);
endinterface

interface urx_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [urx_pkg::DATA_W-1:0]  read_data;
  logic                        tx_valid;
  logic [urx_pkg::BYTE_W-1:0]  tx_byte;
  logic                        rx_irq;
  logic                        accepted;

  modport source (output valid, read_data, tx_valid, tx_byte, rx_irq, accepted, input ready);
  modport sink   (input valid, read_data, tx_valid, tx_byte, rx_irq, accepted, output ready);
endinterface

// ===== rtl/uart_rx_fifo_register_bank_top.sv =====
// Top level of the UART register bank with receive FIFO.
// Depends on urx_pkg, urx_if, urx_ctrl and urx_dp.
//
// Each request transaction (line byte, bus read or bus write) is captured in
// the idle state, then in the execute state updates the FIFO and registers
// and loads the response register; the receive FIFO memory read port is
// registered, so its data is ready for that update. A new request is taken
// as soon as the previous one has been loaded, while its response may still
// wait for the sink; an untaken response stalls the next update. The user
// must make configuration writes while the block is idle; not enforced here.
module uart_rx_fifo_register_bank_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  urx_req_if.sink                        req_i,
  urx_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [urx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urx_pkg::WM_W-1:0]       cfg_data_i
);

  urx_pkg::cmd_t cmd;
  urx_pkg::sts_t sts;

  urx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  urx_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .func_i     (req_i.func),
    .reg_index_i(req_i.reg_index),
    .data_i     (req_i.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .read_data_o(rsp_o.read_data),
    .tx_valid_o (rsp_o.tx_valid),
    .tx_byte_o  (rsp_o.tx_byte),
    .rx_irq_o   (rsp_o.rx_irq),
    .accepted_o (rsp_o.accepted)
  );

  assign rsp_o.valid = sts.out_full;

endmodule

// ===== rtl/urx_ctrl.sv =====
// Controller state machine: takes one transaction, executes it, hands off.
// Depends on urx_pkg for state and command types.
module urx_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  input  urx_pkg::sts_t  sts_i,
  output urx_pkg::cmd_t  cmd_o
);

  urx_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urx_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.drain   = sts_i.out_full & out_ready_i;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      urx_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = urx_pkg::S_EXEC;
        end
      end
      urx_pkg::S_EXEC: begin
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = urx_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = urx_pkg::S_IDLE;
      end
    endcase
  end

  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!sts_i.out_full || out_ready_i))
    else $error("result register overwritten");

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == urx_pkg::S_EXEC && !cmd_o.capture))
    else $error("second transaction taken during execution");

  a_commit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> sts_i.out_full)
    else $error("committed result not held");

endmodule

// ===== rtl/urx_dp.sv =====
// Datapath: receive FIFO memory and pointers, bus registers, result register.
// Depends on urx_pkg; driven by urx_ctrl commands.
module urx_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  urx_pkg::cmd_t                  cmd_i,
  output urx_pkg::sts_t                  sts_o,
  input  logic [urx_pkg::FUNC_W-1:0]     func_i,
  input  logic [urx_pkg::REG_W-1:0]      reg_index_i,
  input  logic [urx_pkg::DATA_W-1:0]     data_i,
  input  logic                           cfg_we_i,
  input  logic [urx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urx_pkg::WM_W-1:0]       cfg_data_i,
  output logic [urx_pkg::DATA_W-1:0]     read_data_o,
  output logic                           tx_valid_o,
  output logic [urx_pkg::BYTE_W-1:0]     tx_byte_o,
  output logic                           rx_irq_o,
  output logic                           accepted_o
);

  logic [urx_pkg::BYTE_W-1:0] mem [urx_pkg::RX_DEPTH];
  logic [urx_pkg::BYTE_W-1:0] rd_q;

  logic [urx_pkg::FUNC_W-1:0] func_q;
  logic [urx_pkg::REG_W-1:0]  idx_q;
  logic [urx_pkg::DATA_W-1:0] data_q;

  logic [urx_pkg::PTR_W-1:0] wpos_q, wpos_d, rpos_q, rpos_d;
  logic [urx_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [urx_pkg::DATA_W-1:0] scaler_q, scaler_d, cpu_q, cpu_d;
  logic                       irq_en_q;
  logic [urx_pkg::WM_W-1:0]   rx_wm_q, tx_wm_q;
  logic                       out_full_q;

  logic [urx_pkg::DATA_W-1:0] rdata_d;
  logic                       tx_valid_d, irq_d, acc_d, mem_we;
  logic [urx_pkg::BYTE_W-1:0] tx_byte_d;
  logic                       full, empty, rxwm;

  function automatic logic [urx_pkg::PTR_W-1:0] next_pos(logic [urx_pkg::PTR_W-1:0] p);
    return (p == urx_pkg::PTR_W'(urx_pkg::RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (cnt_q == urx_pkg::CNT_W'(urx_pkg::RX_DEPTH));
  assign empty = (cnt_q == '0);
  assign rxwm  = (urx_pkg::CMP_W'(cnt_q) > urx_pkg::CMP_W'(rx_wm_q));

  always_comb begin
    wpos_d     = wpos_q;
    rpos_d     = rpos_q;
    cnt_d      = cnt_q;
    scaler_d   = scaler_q;
    cpu_d      = cpu_q;
    rdata_d    = '0;
    tx_valid_d = 1'b0;
    tx_byte_d  = '0;
    irq_d      = 1'b0;
    acc_d      = 1'b0;
    mem_we     = 1'b0;
    unique case (urx_pkg::func_e'(func_q))
      urx_pkg::FUNC_LINE: begin
        if (!full) begin
          mem_we = 1'b1;
          wpos_d = next_pos(wpos_q);
          cnt_d  = cnt_q + 1'b1;
          acc_d  = 1'b1;
        end
        irq_d = irq_en_q && (urx_pkg::CMP_W'(cnt_d) > urx_pkg::CMP_W'(rx_wm_q));
      end
      urx_pkg::FUNC_READ: begin
        case (idx_q)
          urx_pkg::REG_RXDATA: begin
            if (empty) begin
              rdata_d = urx_pkg::RD_EMPTY;
            end else begin
              rdata_d = urx_pkg::DATA_W'(rd_q);
              rpos_d  = next_pos(rpos_q);
              cnt_d   = cnt_q - 1'b1;
            end
          end
          urx_pkg::REG_IP:     rdata_d = urx_pkg::DATA_W'({rxwm, (tx_wm_q != '0)});
          urx_pkg::REG_SCALER: rdata_d = scaler_q;
          urx_pkg::REG_CPUID:  rdata_d = cpu_q;
          default:             rdata_d = '0;
        endcase
      end
      urx_pkg::FUNC_WRITE: begin
        case (idx_q)
          urx_pkg::REG_TXDATA: begin
            tx_valid_d = 1'b1;
            tx_byte_d  = data_q[urx_pkg::BYTE_W-1:0];
          end
          urx_pkg::REG_SCALER: scaler_d = data_q;
          urx_pkg::REG_CPUID: begin
            cpu_d = (data_q == '0 || cpu_q == '0) ? data_q : '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mem_we) begin
      mem[wpos_q] <= data_q[urx_pkg::BYTE_W-1:0];
    end
    rd_q <= mem[rpos_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      idx_q  <= reg_index_i;
      data_q <= data_i;
    end
    if (cmd_i.commit) begin
      read_data_o <= rdata_d;
      tx_valid_o  <= tx_valid_d;
      tx_byte_o   <= tx_byte_d;
      rx_irq_o    <= irq_d;
      accepted_o  <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= '0;
      rpos_q     <= '0;
      cnt_q      <= '0;
      scaler_q   <= '0;
      cpu_q      <= '0;
      irq_en_q   <= 1'b0;
      rx_wm_q    <= '0;
      tx_wm_q    <= '0;
      out_full_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        wpos_q   <= wpos_d;
        rpos_q   <= rpos_d;
        cnt_q    <= cnt_d;
        scaler_q <= scaler_d;
        cpu_q    <= cpu_d;
      end
      if (cmd_i.commit) begin
        out_full_q <= 1'b1;
      end else if (cmd_i.drain) begin
        out_full_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          urx_pkg::CFG_RX_IRQ_EN: irq_en_q <= cfg_data_i[0];
          urx_pkg::CFG_TX_IRQ_EN: ;
          urx_pkg::CFG_RX_WM:     rx_wm_q  <= cfg_data_i;
          urx_pkg::CFG_TX_WM:     tx_wm_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign sts_o.out_full = out_full_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= urx_pkg::CNT_W'(urx_pkg::RX_DEPTH))
    else $error("receive count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || full) |-> (wpos_q == rpos_q))
    else $error("pointers disagree with count");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && full && func_q == urx_pkg::FUNC_LINE) |=> (full && !accepted_o))
    else $error("byte stored into full fifo");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the UART register bank with its receive FIFO.
// Drives line bytes and bus accesses, predicts each response and checks it.
// Depends on urx_pkg, urx_if and the uart_rx_fifo_register_bank_top RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [urx_pkg::FUNC_W-1:0] FUNC_NONE  = 2'd3;
  localparam logic [urx_pkg::REG_W-1:0]  REG_TXCTRL = 3'd2;
  localparam logic [urx_pkg::REG_W-1:0]  REG_RXCTRL = 3'd3;
  localparam logic [urx_pkg::REG_W-1:0]  REG_IE     = 3'd4;
  localparam int STALL_CYCLES = 100;
  localparam int IDLE_PCT     = 38;

  typedef struct packed {
    logic [urx_pkg::FUNC_W-1:0] func;
    logic [urx_pkg::REG_W-1:0]  reg_index;
    logic [urx_pkg::DATA_W-1:0] data;
  } bus_item_t;

  typedef struct packed {
    logic [urx_pkg::DATA_W-1:0] read_data;
    logic                       tx_valid;
    logic [urx_pkg::BYTE_W-1:0] tx_byte;
    logic                       rx_irq;
    logic                       accepted;
  } bank_rsp_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [urx_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [urx_pkg::WM_W-1:0]      cfg_data_i;

  urx_req_if req_if ();
  urx_rsp_if rsp_if ();

  uart_rx_fifo_register_bank_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bus_item_t req_item_q[$];
  bank_rsp_t bank_rsp_q[$];
  bus_item_t drive_item;
  logic      req_taken;
  int        src_idle_pct = IDLE_PCT;
  int        sink_idle_pct = IDLE_PCT;
  int        stall_req = 0;
  int        stall_ack = 0;
  int        stall_left = 0;
  int        mismatch_cnt = 0;
  int        rsp_cnt = 0;
  int        line_cnt = 0;
  int        drop_cnt = 0;
  int        read_cnt = 0;
  int        irq_cnt = 0;

  // predictor state
  logic [urx_pkg::BYTE_W-1:0] rx_mem [urx_pkg::RX_DEPTH];
  logic [urx_pkg::PTR_W-1:0]  wr_pos;
  logic [urx_pkg::PTR_W-1:0]  rd_pos;
  logic [urx_pkg::CNT_W-1:0]  rx_level;
  logic [urx_pkg::DATA_W-1:0] scaler_reg;
  logic [urx_pkg::DATA_W-1:0] cpu_id;
  logic                       cfg_rx_irq_en;
  logic                       cfg_tx_irq_en;
  logic [urx_pkg::WM_W-1:0]   cfg_rx_wm;
  logic [urx_pkg::WM_W-1:0]   cfg_tx_wm;

  function automatic logic [urx_pkg::PTR_W-1:0] ring_next(logic [urx_pkg::PTR_W-1:0] p);
    return (int'(p) == urx_pkg::RX_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic bank_rsp_t register_bank_step(bus_item_t it);
    bank_rsp_t r;
    r = '0;
    case (it.func)
      urx_pkg::FUNC_LINE: begin
        if (int'(rx_level) < urx_pkg::RX_DEPTH) begin
          rx_mem[wr_pos] = it.data[urx_pkg::BYTE_W-1:0];
          wr_pos = ring_next(wr_pos);
          rx_level = rx_level + 1'b1;
          r.accepted = 1'b1;
        end
        if (cfg_rx_irq_en && int'(rx_level) > int'(cfg_rx_wm)) r.rx_irq = 1'b1;
      end
      urx_pkg::FUNC_READ: begin
        case (it.reg_index)
          urx_pkg::REG_RXDATA: begin
            if (rx_level == '0) begin
              r.read_data = urx_pkg::RD_EMPTY;
            end else begin
              r.read_data = {{(urx_pkg::DATA_W-urx_pkg::BYTE_W){1'b0}}, rx_mem[rd_pos]};
              rd_pos = ring_next(rd_pos);
              rx_level = rx_level - 1'b1;
            end
          end
          urx_pkg::REG_IP: begin
            r.read_data[0] = (cfg_tx_wm != '0);
            r.read_data[1] = (int'(rx_level) > int'(cfg_rx_wm));
          end
          urx_pkg::REG_SCALER: r.read_data = scaler_reg;
          urx_pkg::REG_CPUID:  r.read_data = cpu_id;
          default:             r.read_data = '0;
        endcase
      end
      urx_pkg::FUNC_WRITE: begin
        case (it.reg_index)
          urx_pkg::REG_TXDATA: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = it.data[urx_pkg::BYTE_W-1:0];
          end
          urx_pkg::REG_SCALER: scaler_reg = it.data;
          urx_pkg::REG_CPUID: begin
            if (it.data == '0 || cpu_id == '0) cpu_id = it.data;
            else cpu_id = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [urx_pkg::DATA_W-1:0] got,
                                 logic [urx_pkg::DATA_W-1:0] want);
    mismatch_cnt++;
    $display("mismatch %s: got 0x%08h want 0x%08h at %0t ns", what, got, want, $time);
  endtask

  task automatic check_response(bank_rsp_t want);
    if (rsp_if.read_data !== want.read_data)
      report_mismatch("read_data", rsp_if.read_data, want.read_data);
    if (rsp_if.tx_valid !== want.tx_valid)
      report_mismatch("tx_valid", urx_pkg::DATA_W'(rsp_if.tx_valid),
                      urx_pkg::DATA_W'(want.tx_valid));
    if (rsp_if.tx_byte !== want.tx_byte)
      report_mismatch("tx_byte", urx_pkg::DATA_W'(rsp_if.tx_byte),
                      urx_pkg::DATA_W'(want.tx_byte));
    if (rsp_if.rx_irq !== want.rx_irq)
      report_mismatch("rx_irq", urx_pkg::DATA_W'(rsp_if.rx_irq),
                      urx_pkg::DATA_W'(want.rx_irq));
    if (rsp_if.accepted !== want.accepted)
      report_mismatch("accepted", urx_pkg::DATA_W'(rsp_if.accepted),
                      urx_pkg::DATA_W'(want.accepted));
  endtask

  // monitor and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    bank_rsp_t exp_rsp;
    if (!rst_ni) begin
      req_taken     <= 1'b0;
      wr_pos        = '0;
      rd_pos        = '0;
      rx_level      = '0;
      scaler_reg    = '0;
      cpu_id        = '0;
      cfg_rx_irq_en = 1'b0;
      cfg_tx_irq_en = 1'b0;
      cfg_rx_wm     = '0;
      cfg_tx_wm     = '0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          urx_pkg::CFG_RX_IRQ_EN: cfg_rx_irq_en = cfg_data_i[0];
          urx_pkg::CFG_TX_IRQ_EN: cfg_tx_irq_en = cfg_data_i[0];
          urx_pkg::CFG_RX_WM:     cfg_rx_wm     = cfg_data_i;
          urx_pkg::CFG_TX_WM:     cfg_tx_wm     = cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_cnt++;
        if (bank_rsp_q.size() == 0) report_mismatch("unexpected response", rsp_if.read_data, '0);
        else check_response(bank_rsp_q.pop_front());
      end
      if (req_if.valid && req_if.ready) begin
        exp_rsp = register_bank_step('{req_if.func, req_if.reg_index, req_if.data});
        if (req_if.func == urx_pkg::FUNC_LINE) begin
          line_cnt++;
          if (!exp_rsp.accepted) drop_cnt++;
        end
        if (req_if.func == urx_pkg::FUNC_READ) read_cnt++;
        if (exp_rsp.rx_irq) irq_cnt++;
        bank_rsp_q.push_back(exp_rsp);
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (req_item_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          drive_item = req_item_q.pop_front();
          req_if.valid     <= 1'b1;
          req_if.func      <= drive_item.func;
          req_if.reg_index <= drive_item.reg_index;
          req_if.data      <= drive_item.data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response ready, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (stall_req != stall_ack) begin
        stall_ack    <= stall_req;
        stall_left   <= STALL_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic push_item(logic [urx_pkg::FUNC_W-1:0] func, logic [urx_pkg::REG_W-1:0] idx,
                           logic [urx_pkg::DATA_W-1:0] data);
    req_item_q.push_back('{func, idx, data});
  endtask

  task automatic wait_bank_idle();
    while (req_item_q.size() != 0 || req_if.valid || bank_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [urx_pkg::CFG_IDX_W-1:0] idx,
                           logic [urx_pkg::WM_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
  endtask

  task automatic program_bank(logic rx_en, logic tx_en, logic [urx_pkg::WM_W-1:0] rx_wm,
                              logic [urx_pkg::WM_W-1:0] tx_wm);
    cfg_write(urx_pkg::CFG_RX_IRQ_EN, urx_pkg::WM_W'(rx_en));
    cfg_write(urx_pkg::CFG_TX_IRQ_EN, urx_pkg::WM_W'(tx_en));
    cfg_write(urx_pkg::CFG_RX_WM, rx_wm);
    cfg_write(urx_pkg::CFG_TX_WM, tx_wm);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random_items(int n, int line_pct, int read_pct);
    logic [urx_pkg::FUNC_W-1:0] func;
    logic [urx_pkg::REG_W-1:0]  idx;
    logic [urx_pkg::DATA_W-1:0] data;
    int                         pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < line_pct) func = urx_pkg::FUNC_LINE;
      else if (pick < line_pct + read_pct) func = urx_pkg::FUNC_READ;
      else if (pick < 97) func = urx_pkg::FUNC_WRITE;
      else func = FUNC_NONE;
      idx = urx_pkg::REG_W'($urandom_range(7));
      if (func == urx_pkg::FUNC_READ && $urandom_range(99) < 60) idx = urx_pkg::REG_RXDATA;
      pick = $urandom_range(99);
      if (pick < 10) data = '0;
      else if (pick < 15) data = '1;
      else data = $urandom;
      push_item(func, idx, data);
    end
  endtask

  task automatic run_phase(logic rx_en, logic tx_en, logic [urx_pkg::WM_W-1:0] rx_wm,
                           logic [urx_pkg::WM_W-1:0] tx_wm, int n, int line_pct,
                           int read_pct, bit hold_sink, bit pause_src);
    wait_bank_idle();
    program_bank(rx_en, tx_en, rx_wm, tx_wm);
    queue_random_items(n / 2, line_pct, read_pct);
    if (hold_sink) stall_req++;
    if (pause_src) wait_bank_idle();
    queue_random_items(n - n / 2, line_pct, read_pct);
  endtask

  initial begin
    int guard;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    req_if.valid     = 1'b0;
    req_if.func      = '0;
    req_if.reg_index = '0;
    req_if.data      = '0;
    rsp_if.ready     = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    program_bank(1'b1, 1'b0, 5'd0, 5'd16);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_RXDATA, 32'h0);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_TXDATA, 32'h0);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_IP,     32'h0);
    push_item(urx_pkg::FUNC_LINE,  urx_pkg::REG_TXDATA, 32'h0000_0000);
    push_item(urx_pkg::FUNC_LINE,  urx_pkg::REG_CPUID,  32'hFFFF_FFFF);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_IP,     32'h0);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_RXDATA, 32'h0);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_RXDATA, 32'h0);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_RXDATA, 32'h0);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_TXDATA, 32'hFFFF_FFA5);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_TXDATA, 32'h0);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_SCALER, 32'hFFFF_FFFF);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_SCALER, 32'h0);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_SCALER, 32'h0);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_SCALER, 32'h0);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_CPUID,  32'h1234_5678);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_CPUID,  32'h0);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_CPUID,  32'hDEAD_BEEF);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_CPUID,  32'h0);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_CPUID,  32'hFFFF_FFFF);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_CPUID,  32'h0);
    push_item(urx_pkg::FUNC_READ,  urx_pkg::REG_CPUID,  32'h0);
    push_item(urx_pkg::FUNC_WRITE, urx_pkg::REG_RXDATA, 32'hFFFF_FFFF);
    push_item(urx_pkg::FUNC_WRITE, REG_IE,              32'hFFFF_FFFF);
    push_item(urx_pkg::FUNC_READ,  REG_TXCTRL,          32'h0);
    push_item(urx_pkg::FUNC_READ,  REG_RXCTRL,          32'h0);
    push_item(FUNC_NONE,           urx_pkg::REG_RXDATA, 32'hFFFF_FFFF);

    run_phase(1'b1, 1'b1, 5'd0,  5'd16, 140, 45, 35, 1'b0, 1'b1);
    run_phase(1'b0, 1'b0, 5'd16, 5'd0,  140, 70, 15, 1'b0, 1'b0);
    run_phase(1'b1, 1'b0, 5'd15, 5'd1,  140, 75, 15, 1'b1, 1'b0);
    run_phase(1'b1, 1'b1, 5'd16, 5'd16, 140, 20, 65, 1'b0, 1'b0);
    run_phase(1'b0, 1'b1, 5'd3,  5'd8,  140, 50, 40, 1'b0, 1'b0);
    wait_bank_idle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_phase(1'b1, 1'b0, 5'd8,  5'd5,  140, 55, 35, 1'b0, 1'b0);
    wait_bank_idle();
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
    repeat (2) begin
      run_phase(1'($urandom_range(1)), 1'($urandom_range(1)),
                urx_pkg::WM_W'($urandom_range(16)), urx_pkg::WM_W'($urandom_range(16)),
                140, 50, 40, 1'b0, 1'b0);
    end

    guard = 0;
    while ((req_item_q.size() != 0 || req_if.valid || bank_rsp_q.size() != 0) &&
           guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (bank_rsp_q.size() != 0)
      report_mismatch("responses missing", urx_pkg::DATA_W'(bank_rsp_q.size()), '0);

    $display("covered %0d transactions: %0d line bytes (%0d dropped), %0d bus reads",
             rsp_cnt, line_cnt, drop_cnt, read_cnt);
    $display("receive irq pulses %0d, mismatches %0d", irq_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d responses outstanding", bank_rsp_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/urx_pkg.sv
rtl/urx_if.sv
rtl/urx_ctrl.sv
rtl/urx_dp.sv
rtl/uart_rx_fifo_register_bank_top.sv
tb/sv/tb_top.sv
